FILE: rtl/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants for the LSB steganography embedder.
// ----------------------------------------------------------------------------
package lse_pkg;

    localparam int unsigned HdrLenBits = 64;
    localparam int unsigned HdrEncBits = 32;
    localparam int unsigned HdrBits    = HdrLenBits + HdrEncBits;

    localparam logic [7:0] LsbClearMask = 8'hFE;
    localparam logic [7:0] AllOnes      = 8'hFF;

    // register indexes, byte address = 4 * index
    localparam logic [1:0] RegPayloadLength = 2'd0;
    localparam logic [1:0] RegBitsPerChan   = 2'd1;
    localparam logic [1:0] RegEqualize      = 2'd2;

    typedef struct packed {
        logic [31:0] payload_length;
        logic [3:0]  bits_per_channel;
        logic        equalize;
    } t_cfg;

    typedef struct packed {
        logic [6:0]  hdr_count;
        logic [7:0]  cur_byte;
        logic        have_current;
        logic [2:0]  bit_pos;
        logic [31:0] bytes_done;
        logic        finished;
    } t_state;

    typedef struct packed {
        logic [7:0] channel_out;
        logic       payload_taken;
        logic       payload_done;
    } t_result;

endpackage

FILE: rtl/lse_step.sv
// ----------------------------------------------------------------------------
// lse_step
// Per-channel embed logic: header bit insertion, payload bit extraction
// and next-state computation for one channel byte.
// ----------------------------------------------------------------------------
module lse_step (
    input  lse_pkg::t_cfg    i_cfg,
    input  lse_pkg::t_state  i_state,
    input  logic [7:0]       i_channel_in,
    input  logic             i_in_header,
    input  logic             i_first_channel,
    input  logic [7:0]       i_payload_byte,
    input  logic [7:0]       i_fill_bits,
    output lse_pkg::t_state  o_state,
    output lse_pkg::t_result o_result
);
    import lse_pkg::*;

    t_state      st;
    logic [3:0]  k_eff;
    logic [7:0]  mask;
    logic [3:0]  avail;
    logic [15:0] window;
    logic [31:0] bytes_inc;
    logic        done0;
    logic        last;
    logic        complete;
    logic        overrun;
    logic [3:0]  n_bits;
    logic [7:0]  n_mask;
    logic [7:0]  acc;
    logic        hdr_bit;
    logic        hdr_active;
    logic [4:0]  hdr_sub;

    // restart all counters on the first channel of an image
    assign st = i_first_channel ? '0 : i_state;

    always_comb begin
        if (i_cfg.bits_per_channel == 4'd0) begin
            k_eff = 4'd1;
        end else if (i_cfg.bits_per_channel > 4'd8) begin
            k_eff = 4'd8;
        end else begin
            k_eff = i_cfg.bits_per_channel;
        end
    end

    assign mask  = AllOnes >> (4'd8 - k_eff);
    assign avail = 4'd8 - {1'b0, st.bit_pos};

    // remaining bits of the held byte, then the offered byte
    assign window = st.have_current
                  ? (({8'd0, st.cur_byte} >> st.bit_pos) | ({8'd0, i_payload_byte} << avail))
                  : {8'd0, i_payload_byte};

    assign bytes_inc = st.bytes_done + 32'd1;
    assign done0     = st.bytes_done >= i_cfg.payload_length;
    assign last      = bytes_inc >= i_cfg.payload_length;
    assign complete  = st.have_current ? (k_eff >= avail) : (k_eff == 4'd8);
    assign overrun   = st.have_current && (k_eff > avail);

    always_comb begin
        if (done0) begin
            n_bits = 4'd0;
        end else if (overrun && last) begin
            n_bits = avail;
        end else begin
            n_bits = k_eff;
        end
    end

    assign n_mask = (n_bits == 4'd0) ? 8'd0 : (AllOnes >> (4'd8 - n_bits));
    assign acc    = window[7:0] & n_mask;

    // header bit selection
    assign hdr_sub = st.hdr_count[4:0];
    always_comb begin
        hdr_active = 1'b1;
        hdr_bit    = 1'b0;
        if (st.hdr_count < 7'(HdrLenBits)) begin
            hdr_bit = (st.hdr_count < 7'd32) ? i_cfg.payload_length[hdr_sub] : 1'b0;
        end else if (st.hdr_count < 7'(HdrBits)) begin
            hdr_bit = (hdr_sub < 5'd4) ? i_cfg.bits_per_channel[hdr_sub[1:0]] : 1'b0;
        end else begin
            hdr_active = 1'b0;
        end
    end

    always_comb begin
        o_state                = st;
        o_result.channel_out   = i_channel_in;
        o_result.payload_taken = 1'b0;
        if (i_in_header) begin
            if (hdr_active) begin
                o_state.hdr_count    = st.hdr_count + 7'd1;
                o_result.channel_out = (i_channel_in & LsbClearMask) | {7'd0, hdr_bit};
            end
        end else if (st.finished) begin
            if (i_cfg.equalize) begin
                o_result.channel_out = (i_channel_in & ~mask) | (i_fill_bits & mask);
            end
        end else begin
            o_result.channel_out = (i_channel_in & ~mask) | acc;
            if (!done0) begin
                if (!st.have_current) begin
                    o_state.cur_byte       = i_payload_byte;
                    o_result.payload_taken = 1'b1;
                    if (complete) begin
                        o_state.have_current = 1'b0;
                        o_state.bit_pos      = 3'd0;
                        o_state.bytes_done   = bytes_inc;
                    end else begin
                        o_state.have_current = 1'b1;
                        o_state.bit_pos      = k_eff[2:0];
                    end
                end else if (!complete) begin
                    o_state.bit_pos = st.bit_pos + k_eff[2:0];
                end else begin
                    o_state.bytes_done   = bytes_inc;
                    o_state.have_current = 1'b0;
                    o_state.bit_pos      = 3'd0;
                    if (overrun && !last) begin
                        o_state.cur_byte       = i_payload_byte;
                        o_state.have_current   = 1'b1;
                        o_state.bit_pos        = 3'(k_eff - avail);
                        o_result.payload_taken = 1'b1;
                    end
                end
            end
            o_state.finished = done0 || (complete && last);
        end
        o_result.payload_done = o_state.finished;
    end

endmodule

FILE: rtl/lsb_stego_embed.sv
// ----------------------------------------------------------------------------
// lsb_stego_embed
// Hides a payload in the low bits of carrier colour channel bytes, after a
// 96-bit header of length and bits-per-channel.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  input     in         i_valid / o_stall  channel_in, in_header, first_channel,
//                                          payload_byte, fill_bits
//  output    out        o_valid / i_stall  channel_out, payload_taken, payload_done
//  config    in         APB psel/penable   payload_length, bits_per_channel, equalize
//
//  One transaction per cycle in, one per cycle out, while neither side stalls; the result is registered.
//  The embed state advances at the accepting edge, so consecutive channels
//  need no gap. A two-entry output (result register plus skid register)
//  absorbs a downstream stall; o_stall rises only when both are full.
//  Reset (synchronous, active low) clears the embed state, the output
//  valid flags and the registers to 0, 1, 0.
// ----------------------------------------------------------------------------
module lsb_stego_embed (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_channel_in,
    input  logic        i_in_header,
    input  logic        i_first_channel,
    input  logic [7:0]  i_payload_byte,
    input  logic [7:0]  i_fill_bits,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_channel_out,
    output logic        o_payload_taken,
    output logic        o_payload_done,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lse_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_accept;
    logic    out_take;
    logic    cfg_write;
    logic [1:0] reg_index;

    // ------------------------------------------------------------------
    // Configuration port: zero wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.payload_length   <= 32'd0;
            r_cfg.bits_per_channel <= 4'd1;
            r_cfg.equalize         <= 1'b0;
        end else if (cfg_write) begin
            unique case (reg_index)
                RegPayloadLength: r_cfg.payload_length   <= pwdata;
                RegBitsPerChan:   r_cfg.bits_per_channel <= pwdata[3:0];
                RegEqualize:      r_cfg.equalize         <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            RegPayloadLength: prdata = r_cfg.payload_length;
            RegBitsPerChan:   prdata = {28'd0, r_cfg.bits_per_channel};
            RegEqualize:      prdata = {31'd0, r_cfg.equalize};
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Embed logic for the offered channel
    // ------------------------------------------------------------------
    lse_step u_step (
        .i_cfg           (r_cfg),
        .i_state         (r_state),
        .i_channel_in    (i_channel_in),
        .i_in_header     (i_in_header),
        .i_first_channel (i_first_channel),
        .i_payload_byte  (i_payload_byte),
        .i_fill_bits     (i_fill_bits),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    // stall only once the skid entry is occupied
    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid && !o_stall;
    assign out_take  = r_out_valid && !i_stall;

    // advance the embed state on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Result register and skid register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            // result slot frees: drain the skid first, else load new
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_accept;
            end
        end else if (in_accept) begin
            // result held by downstream: park the new one
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= n_result;
            end
        end else if (in_accept) begin
            r_skid <= n_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_channel_out   = r_out.channel_out;
    assign o_payload_taken = r_out.payload_taken;
    assign o_payload_done  = r_out.payload_done;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while result register empty");

    a_hdr_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.hdr_count <= 7'(HdrBits))
        else $error("header bit count beyond header length");

    a_bitpos_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.have_current == (r_state.bit_pos != 3'd0))
        else $error("held payload byte and bit position disagree");

    a_stall_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall && in_accept) |=> r_skid_valid)
        else $error("accepted transaction lost under output stall");

endmodule

FILE: bench/lse_embed_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lse_embed_checker
// Watches both channels and the register port of the embedder, predicts
// every output transaction and compares it field by field.
// ----------------------------------------------------------------------------
module lse_embed_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel of the embedder
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_channel_in,
    input  logic        i_in_header,
    input  logic        i_first_channel,
    input  logic [7:0]  i_payload_byte,
    input  logic [7:0]  i_fill_bits,
    // output channel of the embedder
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_channel_out,
    input  logic        i_payload_taken,
    input  logic        i_payload_done,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    // status for the top
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_bytes_taken
);
    import lse_pkg::*;

    t_cfg        cfg;
    logic [6:0]  hdr_sent;
    logic [7:0]  held_byte;
    logic        byte_held;
    logic [2:0]  bit_idx;
    logic [31:0] bytes_embedded;
    logic        embed_done;
    t_result     expected_q[$];

    task automatic clear_embed_state;
        hdr_sent       = '0;
        held_byte      = '0;
        byte_held      = 1'b0;
        bit_idx        = '0;
        bytes_embedded = '0;
        embed_done     = 1'b0;
    endtask

    // Advance the embed state by one channel and return its result.
    task automatic embed_channel(input logic [7:0] chan, input logic hdr,
                                 input logic first, input logic [7:0] pbyte,
                                 input logic [7:0] fill, output t_result res);
        int         k;
        int         b;
        int         p;
        logic [7:0] mask;
        logic [7:0] acc;
        logic       hdr_bit;
        logic       halt;
        res.channel_out   = chan;
        res.payload_taken = 1'b0;
        if (first) clear_embed_state();
        if (hdr) begin
            hdr_bit = 1'b0;
            p = int'(hdr_sent);
            if (p < HdrLenBits) begin
                if (p < 32) hdr_bit = cfg.payload_length[p];
            end else if (p < HdrBits) begin
                p = p - HdrLenBits;
                if (p < 4) hdr_bit = cfg.bits_per_channel[p];
            end
            // past the header the channel passes through
            if (int'(hdr_sent) < HdrBits) begin
                res.channel_out = (chan & LsbClearMask) | {7'd0, hdr_bit};
                hdr_sent = hdr_sent + 7'd1;
            end
        end else begin
            k = int'(cfg.bits_per_channel);
            if (k < 1) k = 1;
            if (k > 8) k = 8;
            mask = AllOnes >> (8 - k);
            if (embed_done) begin
                if (cfg.equalize) res.channel_out = (chan & ~mask) | (fill & mask);
            end else begin
                acc  = '0;
                halt = 1'b0;
                for (b = 0; b < k && !halt; b++) begin
                    if (bytes_embedded >= cfg.payload_length) begin
                        halt = 1'b1;
                    end else if (!byte_held && res.payload_taken) begin
                        halt = 1'b1;
                    end else begin
                        if (!byte_held) begin
                            held_byte         = pbyte;
                            byte_held         = 1'b1;
                            res.payload_taken = 1'b1;
                        end
                        acc[b]  = held_byte[bit_idx];
                        bit_idx = bit_idx + 3'd1;
                        if (bit_idx == 3'd0) begin
                            byte_held      = 1'b0;
                            bytes_embedded = bytes_embedded + 32'd1;
                        end
                    end
                end
                if (bytes_embedded >= cfg.payload_length) embed_done = 1'b1;
                res.channel_out = (chan & ~mask) | (acc & mask);
            end
        end
        res.payload_done = embed_done;
    endtask

    task automatic note_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_result res;
        t_result want;
        if (!i_rst_n) begin
            cfg.payload_length   <= '0;
            cfg.bits_per_channel <= 4'd1;
            cfg.equalize         <= 1'b0;
            clear_embed_state();
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    RegPayloadLength: cfg.payload_length   <= pwdata;
                    RegBitsPerChan:   cfg.bits_per_channel <= pwdata[3:0];
                    RegEqualize:      cfg.equalize         <= pwdata[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, actual channel %0h taken %0b done %0b",
                             $time, i_channel_out, i_payload_taken, i_payload_done);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_channel_out !== want.channel_out)
                        note_mismatch("channel_out", want.channel_out, i_channel_out);
                    if (i_payload_taken !== want.payload_taken)
                        note_mismatch("payload_taken", {7'd0, want.payload_taken},
                                      {7'd0, i_payload_taken});
                    if (i_payload_done !== want.payload_done)
                        note_mismatch("payload_done", {7'd0, want.payload_done},
                                      {7'd0, i_payload_done});
                    o_checked++;
                    if (want.payload_taken) o_bytes_taken++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                embed_channel(i_channel_in, i_in_header, i_first_channel,
                              i_payload_byte, i_fill_bits, res);
                expected_q.push_back(res);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the embedder with images of header and payload channels under many
// register settings, random idling on both sides and two long output hold-offs.
// ----------------------------------------------------------------------------
module tb;
    import lse_pkg::*;

    localparam int TotalItems    = 1650;
    localparam int HoldOffCycles = 120;
    localparam int CycleLimit    = 200000;
    localparam int MaxPayChans   = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_channel_in;
    logic        i_in_header;
    logic        i_first_channel;
    logic [7:0]  i_payload_byte;
    logic [7:0]  i_fill_bits;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_channel_out;
    logic        o_payload_taken;
    logic        o_payload_done;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int bytes_taken;

    int items_sent;
    int images_sent;
    int settings_used;
    int cycle_count = 0;
    bit tx_eager;

    lsb_stego_embed u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_channel_in    (i_channel_in),
        .i_in_header     (i_in_header),
        .i_first_channel (i_first_channel),
        .i_payload_byte  (i_payload_byte),
        .i_fill_bits     (i_fill_bits),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_channel_out   (o_channel_out),
        .o_payload_taken (o_payload_taken),
        .o_payload_done  (o_payload_done),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    lse_embed_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_channel_in    (i_channel_in),
        .i_in_header     (i_in_header),
        .i_first_channel (i_first_channel),
        .i_payload_byte  (i_payload_byte),
        .i_fill_bits     (i_fill_bits),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_channel_out   (o_channel_out),
        .i_payload_taken (o_payload_taken),
        .i_payload_done  (o_payload_done),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_bytes_taken   (bytes_taken)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending);
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Output side: stall randomly before each transaction, with stretches of
    // none, and twice hold off for a long stretch so the block fills up and
    // stalls its input while the sender keeps offering.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int  wait_cycles;
        int  rx_count;
        bit  rx_eager;
        rx_count = 0;
        rx_eager = 1'b0;
        i_stall  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (rx_count % 64 == 0) rx_eager = ($urandom_range(0, 3) == 0);
            wait_cycles = rx_eager ? 0 : $urandom_range(0, 7);
            if (rx_count == 300 || rx_count == 1000) wait_cycles = HoldOffCycles;
            repeat (wait_cycles) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            // wait for the transaction to complete
            do @(posedge i_clk); while (!o_valid);
            rx_count++;
        end
    end

    // Write one register: setup cycle, then access cycle.
    task automatic reg_write(input logic [1:0] reg_idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_settings(input logic [31:0] len, input logic [3:0] k,
                                 input logic eq);
        reg_write(RegPayloadLength, len);
        reg_write(RegBitsPerChan, {28'd0, k});
        reg_write(RegEqualize, {31'd0, eq});
        settings_used++;
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic drain_results;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Offer one channel after a random gap; return once it is accepted.
    task automatic send_channel(input logic [7:0] chan, input logic hdr,
                                input logic first, input logic [7:0] pbyte,
                                input logic [7:0] fill);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_channel_in    <= chan;
        i_in_header     <= hdr;
        i_first_channel <= first;
        i_payload_byte  <= pbyte;
        i_fill_bits     <= fill;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // One image: header channels, then payload channels to finish the payload
    // (at most 40) and up to 12 more. Occasionally a payload channel slips into the
    // header, or the header is cut short.
    task automatic send_image(input logic [31:0] len, input logic [3:0] k);
        longint unsigned needed;
        int              k_used;
        int              hdr_left;
        int              pay_left;
        bit              pick_hdr;
        k_used = (k == 4'd0) ? 1 : ((k > 4'd8) ? 8 : int'(k));
        needed = (64'(len) * 8 + 64'(k_used) - 1) / 64'(k_used);
        pay_left = (needed > MaxPayChans) ? MaxPayChans : int'(needed);
        pay_left += $urandom_range(0, 12);
        hdr_left = HdrBits + $urandom_range(0, 4);
        if ($urandom_range(0, 7) == 0) hdr_left = $urandom_range(1, HdrBits - 1);
        send_channel(rand_byte(), 1'b1, 1'b1, rand_byte(), rand_byte());
        hdr_left--;
        while (hdr_left + pay_left > 0) begin
            pick_hdr = (hdr_left > 0) && (pay_left == 0 || $urandom_range(0, 15) != 0);
            send_channel(rand_byte(), pick_hdr, 1'b0, rand_byte(), rand_byte());
            if (pick_hdr) hdr_left--;
            else pay_left--;
        end
        images_sent++;
    endtask

    // Unstructured channels, with an occasional restart.
    task automatic send_noise(input int count);
        repeat (count)
            send_channel(rand_byte(), 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 31) == 0), rand_byte(), rand_byte());
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] len;
        logic [3:0]  k;
        logic        eq;
        // hold every input at a known value from time zero
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_channel_in    = '0;
        i_in_header     = 1'b0;
        i_first_channel = 1'b0;
        i_payload_byte  = '0;
        i_fill_bits     = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        items_sent      = 0;
        images_sent     = 0;
        settings_used   = 0;
        tx_eager        = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings leave an empty payload: the first payload channel
        // clears its low bit and finishes, the next passes through.
        send_channel(8'hFF, 1'b0, 1'b0, 8'hFF, 8'hFF);
        send_channel(8'h00, 1'b0, 1'b0, 8'h00, 8'h00);

        // Two bytes at three bits per channel; the byte boundary falls inside
        // a channel and the last channel is short. Equalize fills afterwards.
        drain_results();
        load_settings(32'd2, 4'd3, 1'b1);
        send_channel(8'hFF, 1'b1, 1'b1, 8'h00, 8'h00);
        send_channel(8'h00, 1'b1, 1'b0, 8'hFF, 8'hFF);
        send_channel(8'hFF, 1'b0, 1'b0, 8'hA5, 8'h00);
        // header channel in the middle of the payload
        send_channel(8'h00, 1'b1, 1'b0, 8'h00, 8'hFF);
        send_channel(8'h00, 1'b0, 1'b0, 8'hFF, 8'h00);
        send_channel(8'hFF, 1'b0, 1'b0, 8'h00, 8'hFF);
        send_channel(8'h00, 1'b0, 1'b0, 8'hFF, 8'h00);
        send_channel(8'hFF, 1'b0, 1'b0, 8'h3C, 8'hFF);
        send_channel(8'h00, 1'b0, 1'b0, 8'hFF, 8'h00);
        send_channel(8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);
        send_channel(8'h00, 1'b0, 1'b0, 8'h00, 8'hFF);

        // k above the range acts as 8: one channel carries a whole byte
        drain_results();
        load_settings(32'd1, 4'd15, 1'b0);
        send_channel(8'h5A, 1'b0, 1'b1, 8'hC3, 8'hFF);
        send_channel(8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);

        // k of zero acts as 1; largest length never finishes
        drain_results();
        load_settings(32'hFFFF_FFFF, 4'd0, 1'b1);
        send_channel(8'hFF, 1'b1, 1'b1, 8'h00, 8'h00);
        send_channel(8'h00, 1'b0, 1'b0, 8'hFF, 8'hFF);
        send_channel(8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);

        // Random phases: fresh settings, then an image or some noise.
        while (items_sent < TotalItems) begin
            case ($urandom_range(0, 9))
                0:       len = 32'd0;
                1:       len = 32'hFFFF_FFFF;
                2:       len = $urandom;
                default: len = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 7))
                0:       k = 4'd0;
                1:       k = 4'($urandom_range(9, 15));
                default: k = 4'($urandom_range(1, 8));
            endcase
            eq = 1'($urandom_range(0, 1));
            drain_results();
            load_settings(len, k, eq);
            tx_eager = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) send_image(len, k);
            else send_noise($urandom_range(20, 80));
        end

        drain_results();
        // let any stray result show up
        repeat (4) @(negedge i_clk);

        $display("%0d channels in %0d images under %0d register settings, %0d payload bytes",
                 items_sent, images_sent, settings_used, bytes_taken);
        $display("%0d results compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lse_pkg.sv
rtl/lse_step.sv
rtl/lsb_stego_embed.sv
bench/lse_embed_checker.sv
bench/tb.sv
